>>> rtl/core/sotth_pkg.sv
// Shared types, constants and mixing functions for the seeded token hash.
// No dependencies; imported by every module of the block.
package sotth_pkg;

    localparam logic [31:0] SEED_RESET  = 32'd402904;
    // 1000000 = 2^6 * 15625: the low 6 bits pass through, the rest is reduced mod 15625
    localparam int          LOW_BITS    = 6;
    localparam logic [13:0] MOD_ODD     = 14'd15625;
    // floor(2^40 / 15625); quotient estimate is exact or one short
    localparam logic [26:0] RECIP       = 27'd70368744;
    localparam int          RECIP_SHIFT = 40;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);

    // one finished string waiting for the back end
    typedef struct packed {
        logic [31:0] acc;
        logic [31:0] seed;
    } t_job;

    function automatic logic [31:0] mix_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] a;
        logic [31:0] s;
        a = acc + {24'd0, b};
        s = a + (a << 10);
        return s ^ (s >> 6);
    endfunction

    function automatic logic [31:0] finalize(input logic [31:0] acc);
        logic [31:0] a;
        logic [31:0] x;
        a = acc + (acc << 3);
        x = a ^ (a >> 11);
        return x + (x << 15);
    endfunction

endpackage

>>> rtl/core/sotth_front.sv
// Front end: takes string bytes, keeps the running accumulator and hands
// each finished (mixed, not yet finalized) string to the queue. Uses sotth_pkg.
module sotth_front
    import sotth_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_seed,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic        i_full,
    output logic        o_ready,
    output logic        o_push,
    output t_job        o_job
);

    logic [31:0] r_acc, n_acc;
    logic        r_start, n_start;
    logic        w_take;
    logic [31:0] w_mixed;

    assign o_ready = !i_full;
    assign w_take  = i_valid && o_ready;
    assign w_mixed = mix_byte(r_start ? i_seed : r_acc, i_byte);

    assign o_push    = w_take && i_last;
    assign o_job.acc  = w_mixed;
    assign o_job.seed = i_seed;

    always_comb begin
        n_acc   = r_acc;
        n_start = r_start;
        if (w_take) begin
            n_acc   = w_mixed;
            n_start = i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_start <= 1'b1;
        end else begin
            r_acc   <= n_acc;
            r_start <= n_start;
        end
    end

endmodule

>>> rtl/core/sotth_queue.sv
// Short FIFO of finished strings between front and back end.
// Uses sotth_pkg for the entry type and depth.
module sotth_queue
    import sotth_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QPTR_W:0]     r_count, n_count;
    logic                w_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) n_wptr = r_wptr + 1'b1;
        if (w_pop)  n_rptr = r_rptr + 1'b1;
        if (i_push && !w_pop) n_count = r_count + 1'b1;
        else if (!i_push && w_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/core/sotth_back.sv
// Back end: finalize, reduce mod 1000000 by reciprocal multiply, form the
// check word. Four-stage pipeline ending in the output register. Uses sotth_pkg.
module sotth_back
    import sotth_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [19:0] o_value,
    output logic [31:0] o_check
);

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // stage 1: finalized hash
    logic [31:0] r_h1, r_seed1;
    // stage 2: quotient estimate of (h >> 6) / 15625
    logic [25:0] r_y2;
    logic [LOW_BITS-1:0] r_lo2, r_lo3;
    logic [12:0] r_q2;
    logic [31:0] r_seed2, r_seed3;
    // stage 3: remainder, maybe one modulus too large
    logic [14:0] r_rem3;
    // stage 4: output
    logic [19:0] r_value;
    logic [31:0] r_check;

    logic [52:0] w_prod;
    logic [26:0] w_qm;
    logic [25:0] w_diff;
    logic [14:0] w_rem_fix;
    logic [19:0] w_value;

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_prod = {27'd0, r_h1[31:LOW_BITS]} * {26'd0, RECIP};
    assign w_qm   = {14'd0, r_q2} * {13'd0, MOD_ODD};
    assign w_diff = r_y2 - w_qm[25:0];

    assign w_rem_fix = (r_rem3 >= {1'b0, MOD_ODD}) ? r_rem3 - {1'b0, MOD_ODD} : r_rem3;
    assign w_value   = {w_rem_fix[13:0], r_lo3};

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_h1    <= finalize(i_job.acc);
            r_seed1 <= i_job.seed;
        end
        if (w_rdy2) begin
            r_y2    <= r_h1[31:LOW_BITS];
            r_lo2   <= r_h1[LOW_BITS-1:0];
            r_q2    <= w_prod[RECIP_SHIFT+12:RECIP_SHIFT];
            r_seed2 <= r_seed1;
        end
        if (w_rdy3) begin
            r_rem3  <= w_diff[14:0];
            r_lo3   <= r_lo2;
            r_seed3 <= r_seed2;
        end
        if (w_rdy4) begin
            r_value <= w_value;
            r_check <= {12'd0, w_value} ^ r_seed3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;
    assign o_value = r_value;
    assign o_check = r_check;

endmodule

>>> rtl/core/seeded_one_at_a_time_token_hash.sv
// Seeded one-at-a-time token hash. Bytes arrive on the slave stream, tlast
// marking the final byte of a string; one byte is taken per cycle. The
// front end mixes each byte into the accumulator register (the
// accumulator feedback loop sets the one-byte-per-cycle rate); the first
// byte of a string starts from the seed register. A string's last byte
// pushes the mixed value into a four-entry queue; the back end finalizes it,
// reduces it modulo 1000000 and forms token value and value XOR seed. The
// token passes from its queue entry through the back end's finalize, quotient,
// remainder and output registers to the master stream.
// Input stalls only when the queue is full. Write the seed only while no
// string is in flight.
module seeded_one_at_a_time_token_hash
    import sotth_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata    // [19:0] token_value, [51:20] token_check, pad
);

    logic [31:0] r_seed;
    logic        w_push, w_full, w_empty, w_back_ready;
    t_job        w_push_job, w_head_job;
    logic [19:0] w_value;
    logic [31:0] w_check;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_seed_we) begin
            r_seed <= i_seed_wdata;
        end
    end

    sotth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seed  (r_seed),
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_full  (w_full),
        .o_ready (o_s_axis_tready),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    sotth_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_back_ready),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    sotth_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_empty),
        .i_job   (w_head_job),
        .o_ready (w_back_ready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_value (w_value),
        .o_check (w_check)
    );

    assign o_m_axis_tdata = {4'd0, w_check, w_value};

endmodule

>>> bench/tb_seeded_one_at_a_time_token_hash.sv
// Self-checking bench for seeded_one_at_a_time_token_hash: byte strings in on the slave
// stream, tokens checked on the master stream against a local hash predictor.
// Depends on sotth_pkg and the RTL only.
module tb_seeded_one_at_a_time_token_hash
    import sotth_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_BYTES   = 330;
    localparam int REPORT_MAX    = 10;
    localparam int N_ROWS        = 24;

    typedef enum logic {ROW_BYTE, ROW_SEED} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [31:0] data;       // byte in [7:0], or the new seed
        logic        last;
        bit          typed;      // expected token given in the row
        logic [19:0] exp_value;
        logic [31:0] exp_check;
    } t_script_row;

    typedef struct packed {
        logic [19:0] value;
        logic [31:0] check;
    } t_token;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_seed_we = 1'b0;
    logic [31:0] i_seed_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;    // [7:0] data_byte
    logic        i_s_axis_tlast = 1'b0;  // last_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [55:0] o_m_axis_tdata;         // [19:0] token_value, [51:20] token_check, pad

    seeded_one_at_a_time_token_hash DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_seed_we       (i_seed_we),
        .i_seed_wdata    (i_seed_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // directed strings; all-zero and wrap-to-zero cases have tokens known by hand
    t_script_row script [N_ROWS] = '{
        '{ROW_BYTE, 32'h00,         1'b1, 1'b0, 20'd0, 32'd0},
        '{ROW_SEED, 32'h0,          1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h00,         1'b1, 1'b1, 20'd0, 32'h0},
        '{ROW_BYTE, 32'h00,         1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h00,         1'b1, 1'b1, 20'd0, 32'h0},
        '{ROW_SEED, 32'hFFFF_FFFF,  1'b0, 1'b0, 20'd0, 32'd0},
        // seed + 1 wraps to zero, so the hash stays zero
        '{ROW_BYTE, 32'h01,         1'b1, 1'b1, 20'd0, 32'hFFFF_FFFF},
        '{ROW_BYTE, 32'hFF,         1'b1, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h80,         1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h7F,         1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'hFF,         1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h00,         1'b1, 1'b0, 20'd0, 32'd0},
        '{ROW_SEED, 32'h8000_0000,  1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h01,         1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h02,         1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h04,         1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h08,         1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h10,         1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h20,         1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h40,         1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h80,         1'b1, 1'b0, 20'd0, 32'd0},
        // seed changes mid-string: hash keeps the old seed, check word takes the new one
        '{ROW_BYTE, 32'h41,         1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_SEED, 32'h7FFF_FFFF,  1'b0, 1'b0, 20'd0, 32'd0},
        '{ROW_BYTE, 32'h42,         1'b1, 1'b0, 20'd0, 32'd0}
    };

    // predictor state
    logic [31:0] seed_reg = SEED_RESET;
    logic [31:0] running_hash = '0;
    bit          string_start = 1'b1;

    t_token pending_tokens [$];
    t_token got_token;
    t_token want_token;

    int fail_count    = 0;
    int tokens_seen   = 0;
    int bytes_sent    = 0;
    int strings_sent  = 0;
    int seeds_written = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int rx_stall_pct  = 0;

    logic hold_req = 1'b0;
    bit   hold_taken = 1'b0;
    int   hold_left = 0;

    function automatic logic [31:0] stir_in(input logic [31:0] h, input logic [7:0] c);
        logic [31:0] t;
        t = h + {24'd0, c};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction

    // advance the hash by one accepted byte; returns 1 when a token is due
    function automatic bit hash_byte(input logic [7:0] c, input logic l, output t_token tok);
        logic [31:0] h;
        logic [31:0] rem;
        h = stir_in(string_start ? seed_reg : running_hash, c);
        tok = '0;
        if (!l) begin
            running_hash = h;
            string_start = 1'b0;
            return 1'b0;
        end
        h = avalanche(h);
        running_hash = h;
        string_start = 1'b1;
        rem = h % 32'd1000000;
        tok.value = rem[19:0];
        tok.check = rem ^ seed_reg;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("mismatch at cycle %0d: %s expected %h got %h",
                     cycle_count, what, want, got);
    endtask

    // called at a rising edge; returns at the edge where the byte was taken
    task automatic send_byte(input logic [7:0] c, input logic l, input bit typed,
                             input logic [19:0] ev, input logic [31:0] ec);
        int     gap;
        t_token tok;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= l;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        if (hash_byte(c, l, tok)) begin
            strings_sent++;
            if (typed) begin
                tok.value = ev;
                tok.check = ec;
            end
            pending_tokens.push_back(tok);
        end
    endtask

    task automatic drain_tokens();
        i_s_axis_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        drain_tokens();
        i_seed_we    <= 1'b1;
        i_seed_wdata <= v;
        @(posedge i_clk);
        i_seed_we    <= 1'b0;
        seed_reg = v;
        seeds_written++;
    endtask

    // receiver: check tokens, then pick next tready (long hold-off on request)
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_token.value = o_m_axis_tdata[19:0];
            got_token.check = o_m_axis_tdata[51:20];
            tokens_seen++;
            if (pending_tokens.size() == 0) begin
                report_mismatch("unexpected token (value)", 32'd0, {12'd0, got_token.value});
            end else begin
                want_token = pending_tokens.pop_front();
                if (got_token.value !== want_token.value)
                    report_mismatch("token_value", {12'd0, want_token.value},
                                    {12'd0, got_token.value});
                if (got_token.check !== want_token.check)
                    report_mismatch("token_check", want_token.check, got_token.check);
            end
        end
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens pending",
                     cycle_count, pending_tokens.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int          ph;
        int          k;
        int          len;
        int          phase_bytes;
        int          idle_tab  [4];
        int          stall_tab [4];
        logic [31:0] seed_tab  [4];

        idle_tab  = '{0, 64, 0, 9};
        stall_tab = '{0, 0, 64, 9};
        seed_tab  = '{$urandom(), 32'h0, 32'hFFFF_FFFF, $urandom()};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) begin
            if (script[r].kind == ROW_SEED)
                write_seed(script[r].data);
            else
                send_byte(script[r].data[7:0], script[r].last, script[r].typed,
                          script[r].exp_value, script[r].exp_check);
        end

        for (ph = 0; ph < 4; ph++) begin
            write_seed(seed_tab[ph]);
            send_idle_pct = idle_tab[ph];
            rx_stall_pct <= stall_tab[ph];
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                len = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 40);
                for (k = 0; k < len; k++)
                    send_byte(8'($urandom_range(255)), k == len - 1, 1'b0, '0, '0);
                phase_bytes += len;
            end
        end

        // receiver holds off while short strings keep coming, so the queue fills
        write_seed($urandom());
        send_idle_pct = 0;
        rx_stall_pct <= 0;
        hold_req     <= 1'b1;
        phase_bytes = 0;
        while (phase_bytes < 60) begin
            len = $urandom_range(1, 2);
            for (k = 0; k < len; k++)
                send_byte(8'($urandom_range(255)), k == len - 1, 1'b0, '0, '0);
            phase_bytes += len;
        end

        drain_tokens();
        $display("sent %0d bytes in %0d strings under %0d seed settings",
                 bytes_sent, strings_sent, seeds_written + 1);
        $display("checked %0d tokens, %0d mismatches", tokens_seen, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> seeded_one_at_a_time_token_hash.f
rtl/core/sotth_pkg.sv
rtl/core/sotth_front.sv
rtl/core/sotth_queue.sv
rtl/core/sotth_back.sv
rtl/core/seeded_one_at_a_time_token_hash.sv
bench/tb_seeded_one_at_a_time_token_hash.sv
